// ----- rtl/gemm_pkg.sv -----
// Shared types, codes and saturation helpers of the matrix multiply block.
package gemm_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W = 3;
  localparam int unsigned DIM_W = 4;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned ACC_W = 52;

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_LOAD_C = 2'd2;
  localparam logic [1:0] OP_COMPUTE = 2'd3;

  localparam logic [2:0] REG_TRANSPOSE_A = 3'd0;
  localparam logic [2:0] REG_TRANSPOSE_B = 3'd1;
  localparam logic [2:0] REG_ROWS_M = 3'd2;
  localparam logic [2:0] REG_COLS_N = 3'd3;
  localparam logic [2:0] REG_INNER_K = 3'd4;
  localparam logic [2:0] REG_ALPHA = 3'd5;
  localparam logic [2:0] REG_BETA = 3'd6;

  typedef struct packed {
    logic             first;
    logic             last;
    logic             term;
    logic             run_end;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } slot_t;

  function automatic logic signed [WORD_W-1:0] sat_shift(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-17:0] s;
    s = p[PROD_W-1:16];
    if ((s[PROD_W-17:WORD_W-1] == '0) || (s[PROD_W-17:WORD_W-1] == '1)) begin
      return s[WORD_W-1:0];
    end
    return s[PROD_W-17] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  function automatic logic signed [WORD_W-1:0] sat_acc(input logic signed [ACC_W-1:0] x);
    if ((x[ACC_W-1:WORD_W-1] == '0) || (x[ACC_W-1:WORD_W-1] == '1)) begin
      return x[WORD_W-1:0];
    end
    return x[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

endpackage

// ----- rtl/general_matrix_multiply.sv -----
// Top level of the matrix multiply block: configuration, stores and element sequencer.
// A load word leaves busy low, so loads run one per cycle while no compute is in flight.
// A compute word with nonzero M and N keeps busy high until its last result has strobed;
// results strobe one per element once all of its k steps are summed, paced by the
// single read port of each store feeding the multiply pipeline one k step a cycle.
// Reset restores the registers and clears control; store contents stay undefined.
module general_matrix_multiply #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          opcode,
  input  logic [gemm_pkg::POS_W-1:0]          row_index,
  input  logic [gemm_pkg::POS_W-1:0]          col_index,
  input  logic signed [gemm_pkg::WORD_W-1:0]  element_value,
  output logic                                strobe,
  output logic [gemm_pkg::POS_W-1:0]          out_row,
  output logic [gemm_pkg::POS_W-1:0]          out_col,
  output logic signed [gemm_pkg::WORD_W-1:0]  out_value,
  output logic                                last,
  input  logic                                write_enable,
  input  logic [2:0]                          write_index,
  input  logic [gemm_pkg::WORD_W-1:0]         write_data
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [gemm_pkg::DIM_W-1:0] DIM_MAX = gemm_pkg::DIM_W'(MAX_DIM);

  logic transpose_a, transpose_b;
  logic [gemm_pkg::DIM_W-1:0] rows_m, cols_n, inner_k;
  logic signed [gemm_pkg::WORD_W-1:0] alpha, beta;

  logic running;
  logic [IDX_W-1:0] i, j, k;
  logic [gemm_pkg::DIM_W-1:0] dim_m, dim_n, dim_k, m_last, n_last, k_last;
  logic accept, load_ok, row_end, col_end, k_end;
  gemm_pkg::slot_t slot;

  logic [ADDR_W-1:0] load_addr, a_raddr, b_raddr, c_raddr, c_waddr;
  logic [gemm_pkg::WORD_W-1:0] a_rdata, b_rdata, c_rdata, c_wdata;
  logic we_a, we_b, we_c;

  logic mac_active, res_valid, res_end;
  logic [gemm_pkg::POS_W-1:0] res_row, res_col;
  logic signed [gemm_pkg::WORD_W-1:0] res_value;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [gemm_pkg::POS_W-1:0] r,
                                                input logic [gemm_pkg::POS_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      transpose_a <= 1'b0;
      transpose_b <= 1'b0;
      rows_m <= 4'd8;
      cols_n <= 4'd8;
      inner_k <= 4'd8;
      alpha <= 32'sd65536;
      beta <= '0;
    end else if (write_enable) begin
      case (write_index)
        gemm_pkg::REG_TRANSPOSE_A: transpose_a <= write_data[0];
        gemm_pkg::REG_TRANSPOSE_B: transpose_b <= write_data[0];
        gemm_pkg::REG_ROWS_M: rows_m <= write_data[gemm_pkg::DIM_W-1:0];
        gemm_pkg::REG_COLS_N: cols_n <= write_data[gemm_pkg::DIM_W-1:0];
        gemm_pkg::REG_INNER_K: inner_k <= write_data[gemm_pkg::DIM_W-1:0];
        gemm_pkg::REG_ALPHA: alpha <= write_data;
        gemm_pkg::REG_BETA: beta <= write_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    dim_m = (rows_m > DIM_MAX) ? DIM_MAX : rows_m;
    dim_n = (cols_n > DIM_MAX) ? DIM_MAX : cols_n;
    dim_k = (inner_k > DIM_MAX) ? DIM_MAX : inner_k;
    m_last = dim_m - 1'b1;
    n_last = dim_n - 1'b1;
    k_last = (dim_k == '0) ? '0 : dim_k - 1'b1;
    k_end = gemm_pkg::DIM_W'(k) == k_last;
    col_end = gemm_pkg::DIM_W'(j) == n_last;
    row_end = gemm_pkg::DIM_W'(i) == m_last;
    slot.first = k == '0;
    slot.last = k_end;
    slot.term = dim_k != '0;
    slot.run_end = k_end && col_end && row_end;
    slot.row = gemm_pkg::POS_W'(i);
    slot.col = gemm_pkg::POS_W'(j);
  end

  assign busy = running | mac_active;
  assign accept = start && !busy;
  assign load_ok = ({1'b0, row_index} < DIM_MAX) && ({1'b0, col_index} < DIM_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      i <= '0;
      j <= '0;
      k <= '0;
    end else if (running) begin
      if (!k_end) begin
        k <= k + 1'b1;
      end else begin
        k <= '0;
        if (!col_end) begin
          j <= j + 1'b1;
        end else begin
          j <= '0;
          if (!row_end) begin
            i <= i + 1'b1;
          end else begin
            i <= '0;
            running <= 1'b0;
          end
        end
      end
    end else if (accept && opcode == gemm_pkg::OP_COMPUTE && dim_m != '0 && dim_n != '0) begin
      running <= 1'b1;
      i <= '0;
      j <= '0;
      k <= '0;
    end
  end

  always_comb begin
    load_addr = addr_of(row_index, col_index);
    a_raddr = transpose_a ? addr_of(gemm_pkg::POS_W'(k), gemm_pkg::POS_W'(i))
                          : addr_of(gemm_pkg::POS_W'(i), gemm_pkg::POS_W'(k));
    b_raddr = transpose_b ? addr_of(gemm_pkg::POS_W'(j), gemm_pkg::POS_W'(k))
                          : addr_of(gemm_pkg::POS_W'(k), gemm_pkg::POS_W'(j));
    c_raddr = addr_of(gemm_pkg::POS_W'(i), gemm_pkg::POS_W'(j));
    we_a = accept && load_ok && opcode == gemm_pkg::OP_LOAD_A;
    we_b = accept && load_ok && opcode == gemm_pkg::OP_LOAD_B;
    we_c = res_valid || (accept && load_ok && opcode == gemm_pkg::OP_LOAD_C);
    c_waddr = res_valid ? addr_of(res_row, res_col) : load_addr;
    c_wdata = res_valid ? res_value : element_value;
  end

  gemm_ram #(.WIDTH(gemm_pkg::WORD_W), .DEPTH(DEPTH)) u_store_a (
    .clk(clk), .we(we_a), .waddr(load_addr), .wdata(element_value),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  gemm_ram #(.WIDTH(gemm_pkg::WORD_W), .DEPTH(DEPTH)) u_store_b (
    .clk(clk), .we(we_b), .waddr(load_addr), .wdata(element_value),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  gemm_ram #(.WIDTH(gemm_pkg::WORD_W), .DEPTH(DEPTH)) u_store_c (
    .clk(clk), .we(we_c), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  gemm_mac u_mac (
    .clk(clk),
    .rst(rst),
    .issue(running),
    .issue_slot(slot),
    .alpha(alpha),
    .beta(beta),
    .a_data(a_rdata),
    .b_data(b_rdata),
    .c_data(c_rdata),
    .active(mac_active),
    .res_valid(res_valid),
    .res_row(res_row),
    .res_col(res_col),
    .res_value(res_value),
    .res_end(res_end)
  );

  assign strobe = res_valid;
  assign out_row = res_row;
  assign out_col = res_col;
  assign out_value = res_value;
  assign last = res_end;

endmodule

// ----- rtl/gemm_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module gemm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/gemm_mac.sv -----
// Pipelined scale, multiply and accumulate datapath for one result element at a time.
module gemm_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 issue,
  input  gemm_pkg::slot_t                      issue_slot,
  input  logic signed [gemm_pkg::WORD_W-1:0]   alpha,
  input  logic signed [gemm_pkg::WORD_W-1:0]   beta,
  input  logic signed [gemm_pkg::WORD_W-1:0]   a_data,
  input  logic signed [gemm_pkg::WORD_W-1:0]   b_data,
  input  logic signed [gemm_pkg::WORD_W-1:0]   c_data,
  output logic                                 active,
  output logic                                 res_valid,
  output logic [gemm_pkg::POS_W-1:0]           res_row,
  output logic [gemm_pkg::POS_W-1:0]           res_col,
  output logic signed [gemm_pkg::WORD_W-1:0]   res_value,
  output logic                                 res_end
);

  logic v1, v2, v3, v4;
  gemm_pkg::slot_t slot1, slot2, slot3, slot4;
  logic signed [gemm_pkg::PROD_W-1:0] m1, cb, m2;
  logic signed [gemm_pkg::WORD_W-1:0] b2, b3, ap, cinit3, cinit4;
  logic signed [gemm_pkg::ACC_W-1:0] acc, base, term, acc_next;

  always_comb begin
    base = slot4.first ? {{(gemm_pkg::ACC_W - gemm_pkg::WORD_W){cinit4[gemm_pkg::WORD_W-1]}},
                          cinit4} : acc;
    term = slot4.term ? {{(gemm_pkg::ACC_W - gemm_pkg::PROD_W + 16){m2[gemm_pkg::PROD_W-1]}},
                         m2[gemm_pkg::PROD_W-1:16]} : '0;
    acc_next = base + term;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      res_valid <= v4 && slot4.last;
    end
    slot1 <= issue_slot;
    slot2 <= slot1;
    m1 <= gemm_pkg::PROD_W'(alpha) * gemm_pkg::PROD_W'(a_data);
    cb <= gemm_pkg::PROD_W'(beta) * gemm_pkg::PROD_W'(c_data);
    b2 <= b_data;
    slot3 <= slot2;
    ap <= gemm_pkg::sat_shift(m1);
    cinit3 <= gemm_pkg::sat_shift(cb);
    b3 <= b2;
    slot4 <= slot3;
    m2 <= gemm_pkg::PROD_W'(ap) * gemm_pkg::PROD_W'(b3);
    cinit4 <= cinit3;
    if (v4) begin
      acc <= acc_next;
    end
    res_row <= slot4.row;
    res_col <= slot4.col;
    res_value <= gemm_pkg::sat_acc(acc_next);
    res_end <= slot4.run_end;
  end

  assign active = v1 | v2 | v3 | v4 | res_valid;

endmodule
